@@ hdl/ipv4_header_parser_macros.svh @@
// ----------------------------------------------------------------------------
// ipv4_header_parser_macros.svh
// Assertion macros shared by the IPv4 header parser.
// ----------------------------------------------------------------------------
`ifndef IPV4_HEADER_PARSER_MACROS_SVH
`define IPV4_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked on i_clk outside reset
`define IHP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on i_clk outside reset
`define IHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ipv4hp_pkg.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_pkg
// Types and constants shared by the IPv4 header parser modules.
// ----------------------------------------------------------------------------
package ipv4hp_pkg;

    localparam int unsigned HDR_NUM   = 20;
    localparam int unsigned HDR_IDX_W = 5;

    localparam logic [15:0] HDR_BYTES = 16'd20;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [15:0] SUM_GOOD  = 16'hFFFF;
    localparam logic [3:0]  IP_VER4   = 4'd4;
    localparam logic [3:0]  IHL_BASE  = 4'd5;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNC     = 3'd1,
        ST_BAD_VER   = 3'd2,
        ST_OPTIONS   = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_BAD_CSUM  = 3'd5
    } t_status;

    // One finished packet, handed from the front to the back
    typedef struct packed {
        logic [15:0]             byte_count;
        logic [15:0]             ones_sum;
        logic [HDR_NUM-1:0][7:0] hdr;
    } t_rec;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ hdl/ipv4hp_front.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_front
// Byte intake: counts bytes, captures the 20 header bytes, keeps the
// running ones' complement sum and pushes one record per packet.
// ----------------------------------------------------------------------------
module ipv4hp_front
    import ipv4hp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_rec       o_rec
);

    logic [15:0]             r_count, n_count;
    logic [15:0]             r_sum, n_sum;
    logic [7:0]              r_hold, n_hold;
    logic [HDR_NUM-1:0][7:0] r_hdr, n_hdr;
    logic                    in_hdr;
    logic [16:0]             sum_wide;

    // Byte classification and next-state values
    always_comb begin
        in_hdr   = (r_count < HDR_BYTES);
        n_count  = (r_count < COUNT_MAX) ? r_count + 16'd1 : r_count;
        n_hold   = r_hold;
        n_sum    = r_sum;
        sum_wide = {1'b0, r_sum} + {1'b0, r_hold, i_data_byte};
        n_hdr    = r_hdr;
        if (in_hdr) begin
            n_hdr[r_count[HDR_IDX_W-1:0]] = i_data_byte;
            if (!r_count[0]) begin
                n_hold = i_data_byte;
            end else begin
                // end-around carry
                n_sum = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
        end
    end

    // Counter, sum and high-byte hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_hold  <= '0;
        end else if (i_accept) begin
            r_hold <= n_hold;
            if (i_last) begin
                r_count <= '0;
                r_sum   <= '0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
            end
        end
    end

    // Header byte store, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hdr <= n_hdr;
        end
    end

    assign o_push           = i_accept && i_last;
    assign o_rec.byte_count = n_count;
    assign o_rec.ones_sum   = n_sum;
    assign o_rec.hdr        = n_hdr;

endmodule

@@ hdl/ipv4hp_fifo.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_fifo
// Short record queue between the intake and the result stage.
// ----------------------------------------------------------------------------
module ipv4hp_fifo
    import ipv4hp_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_rec   i_rec,
    input  logic   i_pop,
    output t_rec   o_rec,
    output t_qstat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_rec        = r_mem[r_rd];

    // Pointer wrap
    always_comb begin
        n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

@@ hdl/ipv4hp_back.sv @@
// ----------------------------------------------------------------------------
// ipv4hp_back
// Result stage: runs the header checks on a queued record, zeroes the
// fields on failure and holds the result in an output register.
// ----------------------------------------------------------------------------
module ipv4hp_back
    import ipv4hp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rec        i_rec,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [7:0]  o_service_type,
    output logic [15:0] o_packet_length,
    output logic [15:0] o_identification,
    output logic [15:0] o_flags_fragment,
    output logic [7:0]  o_time_to_live,
    output logic [7:0]  o_protocol_number,
    output logic [15:0] o_header_checksum,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [15:0] o_payload_length
);

    logic        r_valid;
    t_status     r_status, n_status;
    logic [7:0]  r_dscp, r_ttl, r_proto;
    logic [15:0] r_tlen, r_ident, r_frag, r_csum, r_plen;
    logic [31:0] r_src, r_dst;
    logic [15:0] tl;
    logic        ok;

    // Header checks in priority order
    always_comb begin
        tl = {i_rec.hdr[2], i_rec.hdr[3]};
        if (i_rec.byte_count < HDR_BYTES) begin
            n_status = ST_TRUNC;
        end else if (i_rec.hdr[0][7:4] != IP_VER4) begin
            n_status = ST_BAD_VER;
        end else if (i_rec.hdr[0][3:0] != IHL_BASE) begin
            n_status = ST_OPTIONS;
        end else if (tl < HDR_BYTES || tl > i_rec.byte_count) begin
            n_status = ST_BAD_LEN;
        end else if (i_rec.ones_sum != SUM_GOOD) begin
            n_status = ST_BAD_CSUM;
        end else begin
            n_status = ST_OK;
        end
        ok = (n_status == ST_OK);
    end

    assign o_pop = !i_qstat.empty && (!r_valid || !i_stall);

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= n_status;
            r_dscp   <= ok ? i_rec.hdr[1] : '0;
            r_tlen   <= ok ? tl : '0;
            r_ident  <= ok ? {i_rec.hdr[4], i_rec.hdr[5]} : '0;
            r_frag   <= ok ? {i_rec.hdr[6], i_rec.hdr[7]} : '0;
            r_ttl    <= ok ? i_rec.hdr[8] : '0;
            r_proto  <= ok ? i_rec.hdr[9] : '0;
            r_csum   <= ok ? {i_rec.hdr[10], i_rec.hdr[11]} : '0;
            r_src    <= ok ? {i_rec.hdr[12], i_rec.hdr[13], i_rec.hdr[14], i_rec.hdr[15]} : '0;
            r_dst    <= ok ? {i_rec.hdr[16], i_rec.hdr[17], i_rec.hdr[18], i_rec.hdr[19]} : '0;
            r_plen   <= ok ? tl - HDR_BYTES : '0;
        end
    end

    assign o_valid               = r_valid;
    assign o_status              = r_status;
    assign o_service_type        = r_dscp;
    assign o_packet_length       = r_tlen;
    assign o_identification      = r_ident;
    assign o_flags_fragment      = r_frag;
    assign o_time_to_live        = r_ttl;
    assign o_protocol_number     = r_proto;
    assign o_header_checksum     = r_csum;
    assign o_source_address      = r_src;
    assign o_destination_address = r_dst;
    assign o_payload_length      = r_plen;

endmodule

@@ hdl/ipv4_header_parser.sv @@
// ----------------------------------------------------------------------------
// ipv4_header_parser
// IPv4 header checker fed one packet byte per item.
// ----------------------------------------------------------------------------
// Input channel: one packet byte per item (i_data_byte, i_last), accepted when
// i_valid is high and o_stall is low. A byte with i_last high ends the packet.
// Output channel: one result item per packet (status plus decoded header
// fields), taken when o_valid is high and i_stall is low.
// Throughput: one byte per cycle while o_stall is low, payload bytes included;
// the intake adds header byte pairs into a 16-bit ones' complement sum.
// The record of a packet enters the queue at the edge that accepts its final
// byte; o_valid rises once the record moves on into the result register.
// The intake stalls only when the record queue is full, which takes
// FIFO_DEPTH packets queued behind a stalled output register.
// Reset clears the byte count, checksum, queue and output valid. The header
// byte store is not cleared; it is read only once 20 bytes of the current
// packet have arrived.
// ----------------------------------------------------------------------------
`include "ipv4_header_parser_macros.svh"

module ipv4_header_parser
    import ipv4hp_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 2
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_service_type,
    output logic [15:0] o_packet_length,
    output logic [15:0] o_identification,
    output logic [15:0] o_flags_fragment,
    output logic [7:0]  o_time_to_live,
    output logic [7:0]  o_protocol_number,
    output logic [15:0] o_header_checksum,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [15:0] o_payload_length
);

    logic   in_accept;
    logic   push;
    logic   pop;
    t_rec   push_rec;
    t_rec   head_rec;
    t_qstat qstat;
    logic   len_consistent;
    logic   err_fields_zero;

    assign o_stall   = qstat.full;
    assign in_accept = i_valid && !o_stall;

    // Byte intake
    ipv4hp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    // Record queue
    ipv4hp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_stat  (qstat)
    );

    // Checks and result register
    ipv4hp_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_rec                 (head_rec),
        .i_qstat               (qstat),
        .o_pop                 (pop),
        .i_stall               (i_stall),
        .o_valid               (o_valid),
        .o_status              (o_status),
        .o_service_type        (o_service_type),
        .o_packet_length       (o_packet_length),
        .o_identification      (o_identification),
        .o_flags_fragment      (o_flags_fragment),
        .o_time_to_live        (o_time_to_live),
        .o_protocol_number     (o_protocol_number),
        .o_header_checksum     (o_header_checksum),
        .o_source_address      (o_source_address),
        .o_destination_address (o_destination_address),
        .o_payload_length      (o_payload_length)
    );

    // Result field relations used by the checks below
    assign len_consistent  = (o_packet_length >= HDR_BYTES) &&
                             (o_payload_length == o_packet_length - HDR_BYTES);
    assign err_fields_zero = (o_packet_length == '0) && (o_source_address == '0) &&
                             (o_payload_length == '0);

    // Assertions
    `IHP_ASSERT_NOW(a_push_on_last, in_accept, push == i_last, "push must match final byte")
    `IHP_ASSERT_NOW(a_no_overflow, push, !qstat.full, "record pushed into a full queue")
    `IHP_ASSERT_NOW(a_ok_length, o_valid && o_status == ST_OK, len_consistent, "ok, bad length")
    `IHP_ASSERT_NOW(a_err_zero, o_valid && o_status != ST_OK, err_fields_zero, "failed, fields")

endmodule
